// ===== src/bfa_pkg.sv =====
package bfa_pkg;

	localparam int FRAME_W        = 14;
	localparam int DATA_W         = 16;
	localparam int USER_W         = 2;
	localparam int USER_NEW_BIT   = 0;
	localparam int USER_OOM_BIT   = 1;
	localparam int NUM_FRAMES_DEF = 16384;
	localparam int WORD_BITS_DEF  = 32;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CALC = 2'b10
	} state_t;

	typedef struct packed {
		logic found;
		logic full;
	} scan_flags_t;

endpackage

// ===== src/bfa_ram.sv =====
module bfa_ram import bfa_pkg::*; #(
	parameter int WIDTH = WORD_BITS_DEF,
	parameter int DEPTH = NUM_FRAMES_DEF / WORD_BITS_DEF,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/bfa_scan.sv =====
module bfa_scan import bfa_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int IDX_W = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] word,
	output logic [IDX_W-1:0]     idx,
	output logic [WORD_BITS-1:0] set_word,
	output scan_flags_t          flags
);

	logic [WORD_BITS-1:0] inv;
	logic [WORD_BITS-1:0] onehot;

	assign inv    = ~word;
	assign onehot = inv & (~inv + WORD_BITS'(1));

	always_comb begin
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (onehot[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

	assign set_word    = word | onehot;
	assign flags.found = |inv;
	assign flags.full  = &set_word;

endmodule

// ===== src/bitmap_frame_allocator_core.sv =====
// A request's bitmap word is read into the RAM's registered output, then the
// result is registered once the output is free; no new request is taken until
// then. Each one is a bitmap word read followed by bit encode and write-back.
// Frames fill in ascending order, so a word pointer marks the first non-full
// word; words beyond it are treated as zero until written. No clearing pass:
// the block takes requests from the first cycle after arst_n is released.
module bitmap_frame_allocator_core import bfa_pkg::*; #(
	parameter int NUM_FRAMES = NUM_FRAMES_DEF,
	parameter int WORD_BITS  = WORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // [13:0] current_frame, [15:14] zero
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // [13:0] frame_number, [15:14] zero
	output logic [USER_W-1:0] m_tuser   // [0] newly_allocated, [1] out_of_memory
);

	localparam int NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int PTR_W     = $clog2(NUM_WORDS + 1);
	localparam int IDX_W     = $clog2(WORD_BITS);
	localparam int LAST_BITS = NUM_FRAMES - (NUM_WORDS - 1) * WORD_BITS;
	localparam int SUM_W     = PTR_W + IDX_W + 1;
	localparam int FULL_W    = (SUM_W > FRAME_W) ? SUM_W : FRAME_W;

	state_t               state_q;
	logic [PTR_W-1:0]     ptr_q;
	logic                 cur_valid_q;
	logic [FRAME_W-1:0]   cur_frame_s1;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] pad_mask;
	logic [WORD_BITS-1:0] eff_word;
	logic [WORD_BITS-1:0] set_word;
	logic [IDX_W-1:0]     idx;
	scan_flags_t          flags;
	logic                 in_xfer;
	logic                 out_free;
	logic                 in_range;
	logic                 need_alloc;
	logic                 alloc_ok;
	logic                 wr_en;
	logic [FULL_W-1:0]    frame_full;

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			pad_mask[i] = (i >= LAST_BITS);
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign in_xfer    = s_tvalid && s_tready;
	assign out_free   = !m_tvalid || m_tready;
	assign in_range   = (ptr_q < PTR_W'(NUM_WORDS));
	assign need_alloc = (cur_frame_s1 == '0);
	assign alloc_ok   = need_alloc && in_range && flags.found;
	assign wr_en      = (state_q == ST_CALC) && out_free && alloc_ok;

	always_comb begin
		eff_word = cur_valid_q ? rdata : '0;
		if (ptr_q == PTR_W'(NUM_WORDS - 1)) begin
			eff_word = eff_word | pad_mask;
		end
	end

	assign frame_full = FULL_W'(ptr_q) * FULL_W'(WORD_BITS) + FULL_W'(idx);

	bfa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ptr_q[ADDR_W-1:0]),
		.wdata (set_word),
		.re    (in_xfer && in_range),
		.raddr (ptr_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	bfa_scan #(
		.WORD_BITS (WORD_BITS)
	) u_scan (
		.word     (eff_word),
		.idx      (idx),
		.set_word (set_word),
		.flags    (flags)
	);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_frame_s1 <= s_tdata[FRAME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			cur_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (alloc_ok) begin
							if (flags.full) begin
								ptr_q       <= ptr_q + PTR_W'(1);
								cur_valid_q <= 1'b0;
							end else begin
								cur_valid_q <= 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_CALC && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC && out_free) begin
			m_tdata <= '0;
			m_tuser <= '0;
			if (!need_alloc) begin
				m_tdata[FRAME_W-1:0] <= cur_frame_s1;
			end else if (alloc_ok) begin
				m_tdata[FRAME_W-1:0]  <= frame_full[FRAME_W-1:0];
				m_tuser[USER_NEW_BIT] <= 1'b1;
			end else begin
				m_tuser[USER_OOM_BIT] <= 1'b1;
			end
		end
	end

endmodule

// ===== src/bfa_checker.sv =====
module bfa_checker import bfa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [DATA_W-1:0] s_tdata,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic [USER_W-1:0] m_tuser
);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[USER_NEW_BIT] && m_tuser[USER_OOM_BIT]))
		else $error("new allocation and out of memory both set");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USER_OOM_BIT] |-> m_tdata == '0)
		else $error("out of memory with nonzero frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[FRAME_W-1:0] != '0 && (!m_tvalid || m_tready)
		##1 (!m_tvalid || m_tready)
		|=> m_tvalid && m_tdata[FRAME_W-1:0] == $past(s_tdata[FRAME_W-1:0], 2)
			&& m_tuser == '0)
		else $error("assigned frame not passed through");

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (.*);
